@@ rtl/sbus2_dec_pkg.sv @@
`default_nettype none

package sbus2_dec_pkg;

    localparam int BYTE_W       = 8;
    localparam int CHAN_W       = 11;
    localparam int IDX_W        = 5;
    localparam int ERR_W        = 16;
    localparam int POS_W        = 5;
    localparam int FRAME_BYTES  = 25;
    localparam int HELD_BYTES   = FRAME_BYTES - 2;
    localparam int HELD_BITS    = HELD_BYTES * BYTE_W;
    localparam int NUM_ANALOG   = 16;
    localparam int CHAN_BITS    = NUM_ANALOG * CHAN_W;
    localparam int FLAG_W       = 4;
    localparam int OUT_DATA_W   = 40;
    localparam int OUT_USED_W   = IDX_W + CHAN_W + 2 + ERR_W;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [POS_W-1:0] POS_START = POS_W'(0);
    localparam logic [POS_W-1:0] POS_END   = POS_W'(FRAME_BYTES - 1);

    localparam logic [IDX_W-1:0] IDX_DIG0  = IDX_W'(16);
    localparam logic [IDX_W-1:0] IDX_DIG1  = IDX_W'(17);
    localparam logic [IDX_W-1:0] IDX_MIX0  = IDX_W'(18);
    localparam logic [IDX_W-1:0] IDX_MIX1  = IDX_W'(19);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_MIX1;

    localparam logic [CHAN_W-1:0] MIX_OFFSET = CHAN_W'(1024);

    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_START    = 2'd0;
    localparam logic [1:0] REG_END_MASK = 2'd1;
    localparam logic [1:0] REG_END_VAL  = 2'd2;

    localparam logic [BYTE_W-1:0] START_RESET    = 8'h0F;
    localparam logic [BYTE_W-1:0] END_MASK_RESET = 8'h0F;
    localparam logic [BYTE_W-1:0] END_VAL_RESET  = 8'h04;

    typedef struct packed {
        logic [ERR_W-1:0]     errs;
        logic [FLAG_W-1:0]    flags;
        logic [CHAN_BITS-1:0] chans;
    } frame_t;

endpackage

`default_nettype wire

@@ rtl/sbus2_dec_front.sv @@
`default_nettype none

module sbus2_dec_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sbus2_dec_pkg::BYTE_W-1:0]  s_tdata,    // rx_byte
    input  wire logic [sbus2_dec_pkg::BYTE_W-1:0]  start_value,
    input  wire logic [sbus2_dec_pkg::BYTE_W-1:0]  end_mask,
    input  wire logic [sbus2_dec_pkg::BYTE_W-1:0]  end_value,
    output logic                                   push_valid,
    output sbus2_dec_pkg::frame_t                  push_frame,
    input  wire logic                              push_ready
);

    logic [sbus2_dec_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [sbus2_dec_pkg::HELD_BITS-1:0] data_reg, data_next;
    logic [sbus2_dec_pkg::ERR_W-1:0]     tally_reg, tally_next;
    logic                                accept;
    logic                                end_ok;
    logic [sbus2_dec_pkg::ERR_W-1:0]     tally_bump;

    assign s_tready   = push_ready;
    assign accept     = s_tvalid && s_tready;
    assign end_ok     = (s_tdata & end_mask) == end_value;
    assign push_valid = accept && (pos_reg == sbus2_dec_pkg::POS_END) && end_ok;
    assign tally_bump = (tally_reg == '1) ? tally_reg : tally_reg + 1'b1;

    assign push_frame.chans = data_reg[sbus2_dec_pkg::CHAN_BITS-1:0];
    assign push_frame.flags =
        data_reg[sbus2_dec_pkg::CHAN_BITS +: sbus2_dec_pkg::FLAG_W];
    assign push_frame.errs  = tally_reg;

    always_comb begin
        pos_next   = pos_reg;
        data_next  = data_reg;
        tally_next = tally_reg;
        if (accept) begin
            if (pos_reg == sbus2_dec_pkg::POS_START) begin
                if (s_tdata == start_value) begin
                    pos_next = pos_reg + 1'b1;
                end else begin
                    tally_next = tally_bump;
                end
            end else if (pos_reg == sbus2_dec_pkg::POS_END) begin
                pos_next = sbus2_dec_pkg::POS_START;
                if (end_ok) begin
                    tally_next = '0;
                end else begin
                    tally_next = tally_bump;
                end
            end else begin
                // bytes 1..23 shift in from the top, byte 1 ends at the bottom
                data_next = {s_tdata, data_reg[sbus2_dec_pkg::HELD_BITS-1:sbus2_dec_pkg::BYTE_W]};
                pos_next  = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= sbus2_dec_pkg::POS_START;
            tally_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            tally_reg <= tally_next;
        end
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ rtl/sbus2_dec_queue.sv @@
`default_nettype none

module sbus2_dec_queue #(
    parameter int Depth = sbus2_dec_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    input  sbus2_dec_pkg::frame_t push_frame,
    output logic                push_ready,
    output logic                head_valid,
    output sbus2_dec_pkg::frame_t head_frame,
    input  wire logic           pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    sbus2_dec_pkg::frame_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign push_ready = count_reg != CntW'(Depth);
    assign head_valid = count_reg != '0;
    assign head_frame = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_frame;
        end
    end

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("frame pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("frame popped from empty queue");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count did not follow a push");

endmodule

`default_nettype wire

@@ rtl/sbus2_dec_back.sv @@
`default_nettype none

module sbus2_dec_back (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  head_valid,
    input  sbus2_dec_pkg::frame_t                      head_frame,
    output logic                                       pop,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // channel_index, channel_value, failsafe, lost_frame, error_count, zero fill
    output logic [sbus2_dec_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                       m_tlast
);

    logic [sbus2_dec_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                             valid_reg, valid_next;
    logic [sbus2_dec_pkg::IDX_W-1:0]  out_idx_reg;
    logic [sbus2_dec_pkg::CHAN_W-1:0] out_val_reg;
    logic                             out_fs_reg;
    logic                             out_lf_reg;
    logic [sbus2_dec_pkg::ERR_W-1:0]  out_err_reg;
    logic                             out_last_reg;

    logic                             load;
    logic                             at_last;
    logic [sbus2_dec_pkg::CHAN_W-1:0] c1, c3, val;
    logic signed [sbus2_dec_pkg::CHAN_W:0] diff, half;
    logic [sbus2_dec_pkg::CHAN_W:0]   sum;
    logic [sbus2_dec_pkg::CHAN_W-1:0] mix0, mix1;

    assign load    = head_valid && (!valid_reg || m_tready);
    assign at_last = idx_reg == sbus2_dec_pkg::IDX_LAST;
    assign pop     = load && at_last;

    assign c1   = head_frame.chans[1*sbus2_dec_pkg::CHAN_W +: sbus2_dec_pkg::CHAN_W];
    assign c3   = head_frame.chans[3*sbus2_dec_pkg::CHAN_W +: sbus2_dec_pkg::CHAN_W];
    assign diff = $signed({1'b0, c1}) - $signed({1'b0, c3});
    // round toward zero before halving
    assign half = (diff + $signed({{sbus2_dec_pkg::CHAN_W{1'b0}}, diff[sbus2_dec_pkg::CHAN_W]}))
                  >>> 1;
    assign mix0 = half[sbus2_dec_pkg::CHAN_W-1:0] + sbus2_dec_pkg::MIX_OFFSET;
    assign sum  = {1'b0, c1} + {1'b0, c3};
    assign mix1 = sum[sbus2_dec_pkg::CHAN_W:1];

    always_comb begin
        case (idx_reg)
            sbus2_dec_pkg::IDX_DIG0: val = {sbus2_dec_pkg::CHAN_W{head_frame.flags[0]}};
            sbus2_dec_pkg::IDX_DIG1: val = {sbus2_dec_pkg::CHAN_W{head_frame.flags[1]}};
            sbus2_dec_pkg::IDX_MIX0: val = mix0;
            sbus2_dec_pkg::IDX_MIX1: val = mix1;
            default: val = head_frame.chans[idx_reg[3:0]*sbus2_dec_pkg::CHAN_W +:
                                            sbus2_dec_pkg::CHAN_W];
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        if (load) begin
            out_idx_reg  <= idx_reg;
            out_val_reg  <= val;
            out_fs_reg   <= head_frame.flags[3];
            out_lf_reg   <= head_frame.flags[2];
            out_err_reg  <= head_frame.errs;
            out_last_reg <= at_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(sbus2_dec_pkg::OUT_DATA_W - sbus2_dec_pkg::OUT_USED_W){1'b0}},
                       out_err_reg, out_lf_reg, out_fs_reg, out_val_reg, out_idx_reg};

    a_last_restarts_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> idx_reg == '0)
        else $error("frame ended but result index did not restart");

endmodule

`default_nettype wire

@@ rtl/sbus2_frame_decoder_core.sv @@
// SBUS2 frame decoder. Bytes enter on the s_ stream, one word per cycle while
// s_tready is high, and are assembled into 25-byte frames that open on start_value
// and close on an end byte checked under end_mask against end_value. A good frame
// is handed through a queue of QueueDepth decoded frames to the result side, which
// sends its twenty results (16 analog channels, 2 digital, 2 V-tail mixes) one per
// cycle while m_tready is high on the m_ stream, each held in a result register.
// s_tready drops only while the frame queue is full; the result side pops a frame
// with its twentieth result. Registers at byte address 0, 4 and 8.
`default_nettype none

module sbus2_frame_decoder_core #(
    parameter int QueueDepth = sbus2_dec_pkg::QUEUE_DEPTH
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [sbus2_dec_pkg::BYTE_W-1:0]     s_tdata,  // rx_byte
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // channel_index, channel_value, failsafe, lost_frame, error_count, zero fill
    output logic [sbus2_dec_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                      m_tlast,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sbus2_dec_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    logic [sbus2_dec_pkg::BYTE_W-1:0] start_reg, mask_reg, endval_reg;
    logic [1:0]                       reg_sel;
    logic                             cfg_write;

    logic                  push_valid, push_ready, head_valid, pop;
    sbus2_dec_pkg::frame_t push_frame, head_frame;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= sbus2_dec_pkg::START_RESET;
            mask_reg   <= sbus2_dec_pkg::END_MASK_RESET;
            endval_reg <= sbus2_dec_pkg::END_VAL_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                sbus2_dec_pkg::REG_START:    start_reg  <= pwdata[7:0];
                sbus2_dec_pkg::REG_END_MASK: mask_reg   <= pwdata[7:0];
                sbus2_dec_pkg::REG_END_VAL:  endval_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            sbus2_dec_pkg::REG_START:    prdata = {24'b0, start_reg};
            sbus2_dec_pkg::REG_END_MASK: prdata = {24'b0, mask_reg};
            sbus2_dec_pkg::REG_END_VAL:  prdata = {24'b0, endval_reg};
            default:                     prdata = '0;
        endcase
    end

    sbus2_dec_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .start_value (start_reg),
        .end_mask    (mask_reg),
        .end_value   (endval_reg),
        .push_valid  (push_valid),
        .push_frame  (push_frame),
        .push_ready  (push_ready)
    );

    sbus2_dec_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_frame (push_frame),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .pop        (pop)
    );

    sbus2_dec_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
